FILE: design/idu_pkg.sv
// ----------------------------------------------------------------------------
// idu_pkg: shared types and microcode for the integer divider
// Mode codes, control word layout, the control program and the control and
// status groups exchanged between sequencer and datapath.
// ----------------------------------------------------------------------------
package idu_pkg;

  // Mode codes: bit 1 selects 64-bit width, bit 0 selects signed operands
  localparam logic [1:0] FUNC_UDIV32 = 2'd0;
  localparam logic [1:0] FUNC_SDIV32 = 2'd1;
  localparam logic [1:0] FUNC_UDIV64 = 2'd2;
  localparam logic [1:0] FUNC_SDIV64 = 2'd3;

  localparam int unsigned PcW  = 2;
  localparam int unsigned CntW = 6;

  typedef enum logic [1:0] {
    OP_WAIT = 2'd0,  // take an input transfer
    OP_PREP = 2'd1,  // form magnitudes, clear remainder, load bit count
    OP_ITER = 2'd2,  // one quotient bit
    OP_DONE = 2'd3   // sign fix and hand off to the output register
  } uop_e;

  typedef enum logic [1:0] {
    JC_NONE     = 2'd0,
    JC_NO_INPUT = 2'd1,
    JC_CNT_NZ   = 2'd2,
    JC_OUT_BUSY = 2'd3
  } jcond_e;

  typedef struct packed {
    uop_e           op;
    jcond_e         cond;
    logic [PcW-1:0] target;
  } uword_t;

  // Jump to target when the condition holds, else fall through to the next step
  localparam uword_t UROM [2**PcW] = '{
    '{op: OP_WAIT, cond: JC_NO_INPUT, target: PcW'(0)},
    '{op: OP_PREP, cond: JC_NONE,     target: PcW'(0)},
    '{op: OP_ITER, cond: JC_CNT_NZ,   target: PcW'(2)},
    '{op: OP_DONE, cond: JC_OUT_BUSY, target: PcW'(3)}
  };

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
  } ctrl_t;

  typedef struct packed {
    logic cnt_nz;
  } status_t;

endpackage

FILE: design/idu_datapath.sv
// ----------------------------------------------------------------------------
// idu_datapath: restoring division datapath
// Operand capture, magnitude forming, one shift-and-subtract step per cycle
// and the final sign and width fix of the quotient.
// ----------------------------------------------------------------------------
module idu_datapath (
  input  logic            clk_i,
  input  idu_pkg::ctrl_t  ctrl_i,
  input  logic [1:0]      func_i,
  input  logic [63:0]     dividend_i,
  input  logic [63:0]     divisor_i,
  output idu_pkg::status_t stat_o,
  output logic [63:0]     quotient_o
);
  import idu_pkg::*;

  logic [1:0]      func_q;
  logic [63:0]     x_q, y_q;
  logic [63:0]     num_q, num_d;
  logic [63:0]     den_q, den_d;
  logic [63:0]     rem_q, rem_d;
  logic [63:0]     quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic            zero_q, zero_d;

  logic        is64, sgn, na, nb;
  logic [63:0] xa, yb, xneg, yneg, a_mag, b_mag;
  logic [64:0] sh, diff;
  logic        qbit;
  logic [63:0] qneg, qsel;

  assign is64 = func_q[1];
  assign sgn  = func_q[0];

  always_comb begin
    xa    = is64 ? x_q : {32'b0, x_q[31:0]};
    yb    = is64 ? y_q : {32'b0, y_q[31:0]};
    na    = sgn & (is64 ? x_q[63] : x_q[31]);
    nb    = sgn & (is64 ? y_q[63] : y_q[31]);
    xneg  = 64'd0 - xa;
    yneg  = 64'd0 - yb;
    a_mag = na ? (is64 ? xneg : {32'b0, xneg[31:0]}) : xa;
    b_mag = nb ? (is64 ? yneg : {32'b0, yneg[31:0]}) : yb;
  end

  // The shifted remainder keeps its carry-out as bit 64 for the compare
  assign sh   = {rem_q, num_q[63]};
  assign diff = sh - {1'b0, den_q};
  assign qbit = ~diff[64];

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    if (ctrl_i.prep) begin
      // 32-bit modes start with the dividend in the upper half
      num_d  = is64 ? a_mag : {a_mag[31:0], 32'b0};
      den_d  = b_mag;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = is64 ? CntW'(63) : CntW'(31);
      neg_d  = na ^ nb;
      zero_d = (yb == 64'd0);
    end else if (ctrl_i.step) begin
      num_d = {num_q[62:0], 1'b0};
      rem_d = qbit ? diff[63:0] : sh[63:0];
      quo_d = {quo_q[62:0], qbit};
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      func_q <= func_i;
      x_q    <= dividend_i;
      y_q    <= divisor_i;
    end
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  assign stat_o.cnt_nz = (cnt_q != '0);

  always_comb begin
    qneg = 64'd0 - quo_q;
    qsel = neg_q ? qneg : quo_q;
    if (zero_q) begin
      quotient_o = '0;
    end else if (is64) begin
      quotient_o = qsel;
    end else begin
      quotient_o = {32'b0, qsel[31:0]};
    end
  end

endmodule

FILE: design/integer_divider_unit.sv
// ----------------------------------------------------------------------------
// integer_divider_unit: signed and unsigned restoring integer divider
// Divides 32- or 64-bit operands, truncating toward zero, under a small
// microcoded control program.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with func_i, dividend_i and
//   divisor_i. func_i selects unsigned 32, signed 32, unsigned 64 or signed 64.
//   Output channel: out_valid_o / out_stall_i with quotient_o. A transfer
//   happens at a clock edge where valid is high and stall is low.
//   One item is in the datapath at a time. After an input transfer the
//   sequencer spends one step forming magnitudes, one step per quotient bit
//   (32 or 64), and one step writing the output register. The next input is
//   taken in the cycle after the result is written, even while that result
//   still waits in the output register, so a new item does not start until
//   the last one has been written.
//   If the receiver stalls, the finished quotient waits in the final step until
//   the output register is free; no result is dropped.
//   A zero divisor gives a zero quotient. rst_ni clears the program counter and
//   the output valid; the block then waits for input.
// ----------------------------------------------------------------------------
module integer_divider_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] quotient_o
);
  import idu_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  uword_t         uw;
  logic           take;
  logic           out_valid_q, out_valid_d;
  logic [63:0]    quot_q;
  logic           out_busy, out_write;
  ctrl_t          ctrl;
  status_t        stat;
  logic [63:0]    dp_quot;

  assign uw         = UROM[pc_q];
  assign in_stall_o = (uw.op != OP_WAIT);
  assign out_busy   = out_valid_q & out_stall_i;
  assign out_write  = (uw.op == OP_DONE) & ~out_busy;

  always_comb begin
    case (uw.cond)
      JC_NONE:     take = 1'b0;
      JC_NO_INPUT: take = ~in_valid_i;
      JC_CNT_NZ:   take = stat.cnt_nz;
      JC_OUT_BUSY: take = out_busy;
      default:     take = 1'b0;
    endcase
    pc_d = take ? uw.target : pc_q + PcW'(1);
  end

  assign ctrl.load = (uw.op == OP_WAIT) & in_valid_i;
  assign ctrl.prep = (uw.op == OP_PREP);
  assign ctrl.step = (uw.op == OP_ITER);

  idu_datapath u_datapath (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .func_i     (func_i),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .stat_o     (stat),
    .quotient_o (dp_quot)
  );

  // Hold the result until its transfer, drop valid after it
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_write) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_write) begin
      quot_q <= dp_quot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign quotient_o  = quot_q;

endmodule

FILE: sim/tb_integer_divider_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_divider_unit: self-checking bench for the integer divider
// Sends corner cases and random operands in all four modes. Sender gaps and
// receiver stalls are random, and there is one long output hold-off. Every
// quotient is checked in order against a shift-and-subtract model in the bench.
// ----------------------------------------------------------------------------
module tb_integer_divider_unit;
  import idu_pkg::*;

  localparam int unsigned LongHold    = 400;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned MaxReports  = 10;
  localparam logic [63:0] AllOnes     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinS64      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MinS32      = 64'h0000_0000_8000_0000;

  typedef struct {
    logic [1:0]  func;
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic [63:0] quotient;
  } division_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i      = FUNC_UDIV32;
  logic [63:0] dividend_i  = '0;
  logic [63:0] divisor_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] quotient_o;

  division_t   pending_quotients[$];
  int unsigned send_idle_pct      = 0;
  int unsigned recv_stall_pct     = 0;
  int unsigned hold_requests      = 0;
  int unsigned holds_served       = 0;
  int unsigned hold_left          = 0;
  int unsigned failure_count      = 0;
  int unsigned quotients_checked  = 0;
  int unsigned zero_divisor_count = 0;
  int unsigned mode_count [4];

  integer_divider_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .dividend_i  (dividend_i),
    .divisor_i   (divisor_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .quotient_o  (quotient_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Unsigned restoring division over the low width bits; carry-out of the
  // partial remainder forces a subtract.
  function automatic logic [63:0] shift_subtract(input logic [63:0] num,
                                                 input logic [63:0] den,
                                                 input int unsigned width);
    logic [63:0] rem;
    logic [63:0] q;
    logic        carry;
    rem = '0;
    q   = '0;
    if (den == '0) return '0;
    for (int b = int'(width) - 1; b >= 0; b--) begin
      carry = rem[63];
      rem   = {rem[62:0], num[b]};
      if (carry || rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] predict_quotient(input logic [1:0]  func,
                                                   input logic [63:0] x,
                                                   input logic [63:0] y);
    logic [31:0] a32;
    logic [31:0] b32;
    logic [63:0] a64;
    logic [63:0] b64;
    logic [63:0] q;
    q = '0;
    case (func)
      FUNC_UDIV32: q = shift_subtract({32'b0, x[31:0]}, {32'b0, y[31:0]}, 32);
      FUNC_SDIV32: begin
        a32 = x[31] ? -x[31:0] : x[31:0];
        b32 = y[31] ? -y[31:0] : y[31:0];
        q   = shift_subtract({32'b0, a32}, {32'b0, b32}, 32);
        if (x[31] != y[31]) q = -q;
        q = {32'b0, q[31:0]};
      end
      FUNC_UDIV64: q = shift_subtract(x, y, 64);
      FUNC_SDIV64: begin
        a64 = x[63] ? -x : x;
        b64 = y[63] ? -y : y;
        q   = shift_subtract(a64, b64, 64);
        if (x[63] != y[63]) q = -q;
      end
      default: q = '0;
    endcase
    return q;
  endfunction

  task automatic note_failure(input string what);
    failure_count++;
    if (failure_count <= MaxReports) $display("%0t ns: %s", $time, what);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= LongHold - 1;
      out_stall_i  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    division_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      quotients_checked++;
      if (pending_quotients.size() == 0) begin
        note_failure($sformatf("unexpected quotient %h", quotient_o));
      end else begin
        want = pending_quotients.pop_front();
        if (quotient_o !== want.quotient)
          note_failure($sformatf("mode %0d: %h / %h expected %h got %h", want.func,
                                 want.dividend, want.divisor, want.quotient, quotient_o));
      end
    end
  end

  task automatic set_idle(input int unsigned sender_pct, input int unsigned receiver_pct);
    send_idle_pct = sender_pct;
    recv_stall_pct <= receiver_pct;
  endtask

  task automatic send_division(input logic [1:0] f, input logic [63:0] a,
                               input logic [63:0] b);
    division_t item;
    item.func     = f;
    item.dividend = a;
    item.divisor  = b;
    item.quotient = predict_quotient(f, a, b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      dividend_i <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    dividend_i <= a;
    divisor_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_quotients.push_back(item);
    mode_count[f]++;
    if (f[1] ? (b == '0) : (b[31:0] == '0)) zero_divisor_count++;
  endtask

  // Drop valid and hold until every quotient in flight has been checked
  task automatic wait_for_quotients();
    in_valid_i <= 1'b0;
    while (pending_quotients.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(8))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(15));
      2: v = 64'd1 << $urandom_range(63);
      3: v = ~(64'd1 << $urandom_range(63));
      4: v = -64'($urandom_range(1, 1000));
      5: v = {$urandom, 1'b1, 31'($urandom)};
      6: v = {$urandom, 32'b0};
      7: v = {$urandom, $urandom} >> $urandom_range(63);
      default: v = $urandom_range(1) ? MinS64 : AllOnes;
    endcase
    return v;
  endfunction

  task automatic test_corner_cases();
    send_division(FUNC_UDIV32, 64'd12345, 64'd0);
    send_division(FUNC_SDIV32, MinS32, 64'd0);
    send_division(FUNC_UDIV64, AllOnes, 64'd0);
    send_division(FUNC_SDIV64, MinS64, 64'd0);
    // Divisor with zero low half is a zero divisor in 32-bit modes
    send_division(FUNC_UDIV32, 64'd77, 64'hABCD_0000_0000_0000);
    send_division(FUNC_SDIV32, MinS32, 64'h0000_0000_FFFF_FFFF);
    send_division(FUNC_SDIV64, MinS64, AllOnes);
    send_division(FUNC_SDIV64, MinS64, 64'd1);
    send_division(FUNC_SDIV64, MinS64, MinS64);
    send_division(FUNC_UDIV32, 64'hDEAD_BEEF_0000_0064, 64'hFFFF_FFFF_0000_0007);
    send_division(FUNC_SDIV32, 64'h1234_5678_FFFF_FFF9, 64'hFFFF_FFFF_0000_0002);
    send_division(FUNC_UDIV32, 64'h0000_0000_FFFF_FFFF, 64'd1);
    send_division(FUNC_UDIV64, AllOnes, 64'd1);
    send_division(FUNC_UDIV64, AllOnes, AllOnes);
    send_division(FUNC_UDIV64, AllOnes, 64'h8000_0000_0000_0001);
    send_division(FUNC_UDIV64, MinS64, AllOnes);
    send_division(FUNC_UDIV64, 64'd5, 64'd9);
    send_division(FUNC_SDIV64, -64'd7, 64'd2);
    send_division(FUNC_SDIV64, 64'd7, -64'd2);
    send_division(FUNC_SDIV64, -64'd7, -64'd2);
    send_division(FUNC_SDIV32, 64'd7, 64'h0000_0000_FFFF_FFFE);
    send_division(FUNC_UDIV32, 64'd0, 64'h0000_0000_8000_0000);
  endtask

  task automatic test_random_mix(input int unsigned count);
    logic [1:0]  f;
    logic [63:0] a;
    logic [63:0] b;
    repeat (count) begin
      f = 2'($urandom_range(3));
      a = rand_operand();
      b = rand_operand();
      // Aim some signed items at the overflow corner
      if ($urandom_range(24) == 0) begin
        f = $urandom_range(1) ? FUNC_SDIV64 : FUNC_SDIV32;
        a = f[1] ? MinS64 : {32'($urandom), MinS32[31:0]};
        b = AllOnes;
      end
      send_division(f, a, b);
    end
  endtask

  // Hold the output long enough that the block fills and stalls its input
  task automatic test_output_hold_off();
    set_idle(0, 0);
    hold_requests <= hold_requests + 1;
    repeat (6) send_division(FUNC_UDIV64, {$urandom, $urandom}, 64'($urandom_range(1, 255)));
    wait_for_quotients();
  endtask

  task automatic test_input_pause();
    set_idle(24, 73);
    repeat (5) send_division(2'($urandom_range(3)), rand_operand(), rand_operand());
    wait_for_quotients();
    repeat (5) send_division(2'($urandom_range(3)), rand_operand(), rand_operand());
    wait_for_quotients();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idle(24, 73);
    test_corner_cases();
    test_random_mix(125);
    set_idle(73, 24);
    test_random_mix(125);
    set_idle(0, 0);
    test_random_mix(125);
    test_output_hold_off();
    test_input_pause();

    wait_for_quotients();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_quotients.size() != 0)
      note_failure($sformatf("%0d quotients never arrived", pending_quotients.size()));

    $display("covered %0d divisions (u32 %0d, s32 %0d, u64 %0d, s64 %0d), %0d by zero",
             mode_count[0] + mode_count[1] + mode_count[2] + mode_count[3],
             mode_count[0], mode_count[1], mode_count[2], mode_count[3],
             zero_divisor_count);
    $display("%0d quotients compared under random gaps, stalls and a long hold-off, %0d failures",
             quotients_checked, failure_count);
    if (failure_count == 0) begin
      $display("integer_divider_unit test passed");
    end else begin
      $display("integer_divider_unit test failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout with %0d quotients outstanding", pending_quotients.size());
    $display("integer_divider_unit test failed");
    $finish;
  end

endmodule

FILE: files.f
design/idu_pkg.sv
design/idu_datapath.sv
design/integer_divider_unit.sv
sim/tb_integer_divider_unit.sv
